// ----- rtl/ppc_pkg.sv -----
// ----------------------------------------------------------------------------
// ppc_pkg: shared types and constants for the planar pose composer
// Fixed-point widths, CORDIC constants, arctangent table and the side data
// that travels with each request through the pipeline.
// ----------------------------------------------------------------------------
package ppc_pkg;

  // Port formats
  localparam int COORD_WIDTH   = 32;
  localparam int ANGLE_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;

  // Binary angle widened to 32 bits, 2^31 = pi
  localparam int ANGLE_SHIFT = 32 - ANGLE_WIDTH;
  localparam int Z_W         = 33;
  localparam int STAGE_W     = $clog2(CORDIC_STAGES);
  localparam int ATAN_IDX_W  = 5;

  // Cosine / sine in Q2.30 with sign margin
  localparam int TRIG_FRAC = 30;
  localparam int TRIG_W    = 33;

  // Rotation operand (difference needs one extra bit) and its split
  localparam int WIDE_W  = COORD_WIDTH + 1;
  localparam int SPLIT   = (WIDE_W + 1) / 2;
  localparam int HI_W    = WIDE_W - SPLIT;
  localparam int LP_W    = SPLIT + 1 + TRIG_W;
  localparam int HP_W    = HI_W + TRIG_W;
  localparam int LS_W    = LP_W + 1;
  localparam int HS_W    = HP_W + 1;
  localparam int ACC_A_W = HS_W + SPLIT;
  localparam int ACC_W   = ((ACC_A_W > LS_W) ? ACC_A_W : LS_W) + 1;
  localparam int ROT_W   = ACC_W - TRIG_FRAC;
  localparam int SUM_W   = ROT_W + 1;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);
  localparam logic signed [Z_W-1:0]    HALF_TURN   = Z_W'(64'sd1 <<< 31);
  localparam logic signed [ANGLE_WIDTH-1:0] QUARTER_TURN =
    ANGLE_WIDTH'(64'sd1 <<< (ANGLE_WIDTH - 2));
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (TRIG_FRAC - 1));

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    FUNC_COMPOSE = 2'd0,
    FUNC_MAP     = 2'd1,
    FUNC_DIFF    = 2'd2
  } ppc_func_e;

  // CORDIC vector and residual angle
  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [Z_W-1:0]    z;
  } ppc_rot_t;

  // Per-request side data
  typedef struct packed {
    logic                           zero;   // unused mode, all outputs zero
    logic                           skip;   // pass operand, no rotation
    logic                           flip;   // heading turned by pi
    logic                           neg;    // rotate by negated heading
    logic signed [WIDE_W-1:0]       a;
    logic signed [WIDE_W-1:0]       b;
    logic signed [COORD_WIDTH-1:0]  off_x;
    logic signed [COORD_WIDTH-1:0]  off_y;
    logic signed [ANGLE_WIDTH-1:0]  angle;
  } ppc_side_t;

  // atan(2^-i) as a binary angle, 2^31 = pi
  function automatic logic signed [Z_W-1:0] ppc_atan(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41721;
      5'd15:   v = 32'd20860;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2607;
      5'd19:   v = 32'd1303;
      5'd20:   v = 32'd651;
      5'd21:   v = 32'd325;
      5'd22:   v = 32'd162;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return $signed({1'b0, v});
  endfunction

endpackage

// ----- rtl/ppc_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// ppc_cordic_cell: one CORDIC micro-rotation
// Registered stage with its own valid; passes the side data along.
// ----------------------------------------------------------------------------
module ppc_cordic_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [ppc_pkg::STAGE_W-1:0]        stage_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  ppc_pkg::ppc_rot_t                  in_rot_i,
  input  ppc_pkg::ppc_side_t                 in_side_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output ppc_pkg::ppc_rot_t                  out_rot_o,
  output ppc_pkg::ppc_side_t                 out_side_o
);

  logic                  valid_q;
  logic                  load;
  ppc_pkg::ppc_rot_t     rot_d, rot_q;
  ppc_pkg::ppc_side_t    side_q;
  logic signed [ppc_pkg::TRIG_W-1:0] x_sh, y_sh;
  logic signed [ppc_pkg::Z_W-1:0]    atan_v;

  assign load       = !valid_q || !out_stall_i;
  assign in_stall_o = !load;

  assign x_sh   = in_rot_i.x >>> stage_i;
  assign y_sh   = in_rot_i.y >>> stage_i;
  assign atan_v = ppc_pkg::ppc_atan(ppc_pkg::ATAN_IDX_W'(stage_i));

  always_comb begin
    if (!in_rot_i.z[ppc_pkg::Z_W-1]) begin
      rot_d.x = in_rot_i.x - y_sh;
      rot_d.y = in_rot_i.y + x_sh;
      rot_d.z = in_rot_i.z - atan_v;
    end else begin
      rot_d.x = in_rot_i.x + y_sh;
      rot_d.y = in_rot_i.y - x_sh;
      rot_d.z = in_rot_i.z + atan_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      rot_q  <= rot_d;
      side_q <= in_side_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rot_o   = rot_q;
  assign out_side_o  = side_q;

endmodule

// ----- rtl/ppc_rotate.sv -----
// ----------------------------------------------------------------------------
// ppc_rotate: rotation by (c, s), rounding, offset add and saturation
// Five registered stages: sign fix, split products, partial sums,
// round and select, offset add with clamp.
// ----------------------------------------------------------------------------
module ppc_rotate (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  ppc_pkg::ppc_rot_t                      in_rot_i,
  input  ppc_pkg::ppc_side_t                     in_side_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [ppc_pkg::COORD_WIDTH-1:0] out_x_o,
  output logic signed [ppc_pkg::COORD_WIDTH-1:0] out_y_o,
  output logic signed [ppc_pkg::ANGLE_WIDTH-1:0] out_angle_o,
  output logic                                   saturated_o
);

  localparam int NST = 5;

  logic [NST-1:0] valid_q;
  logic [NST-1:0] load;

  // stage 0: cosine and signed sine
  logic signed [ppc_pkg::TRIG_W-1:0] c_q, s_q;
  ppc_pkg::ppc_side_t                side0_q;
  // stage 1: partial products
  logic signed [ppc_pkg::LP_W-1:0]   alc_q, bls_q, als_q, blc_q;
  logic signed [ppc_pkg::HP_W-1:0]   ahc_q, bhs_q, ahs_q, bhc_q;
  ppc_pkg::ppc_side_t                side1_q;
  // stage 2: partial sums
  logic signed [ppc_pkg::HS_W-1:0]   hx_q, hy_q;
  logic signed [ppc_pkg::LS_W-1:0]   lx_q, ly_q;
  ppc_pkg::ppc_side_t                side2_q;
  // stage 3: rounded rotation
  logic signed [ppc_pkg::ROT_W-1:0]  rx_q, ry_q;
  ppc_pkg::ppc_side_t                side3_q;
  // stage 4: results
  logic signed [ppc_pkg::COORD_WIDTH-1:0] x_q, y_q;
  logic signed [ppc_pkg::ANGLE_WIDTH-1:0] angle_q;
  logic                                   sat_q;

  logic        [ppc_pkg::SPLIT-1:0] al, bl;
  logic signed [ppc_pkg::HI_W-1:0]  ah, bh;
  logic signed [ppc_pkg::ACC_W-1:0] accx, accy;
  logic signed [ppc_pkg::SUM_W-1:0] sumx, sumy;
  logic signed [ppc_pkg::COORD_WIDTH-1:0] x_d, y_d;
  logic        satx, saty;

  // bubbles collapse: a stage loads when empty or when the next one moves
  always_comb begin
    load[4] = !valid_q[4] || !out_stall_i;
    load[3] = !valid_q[3] || load[4];
    load[2] = !valid_q[2] || load[3];
    load[1] = !valid_q[1] || load[2];
    load[0] = !valid_q[0] || load[1];
  end
  assign in_stall_o = !load[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (load[0]) valid_q[0] <= in_valid_i;
      if (load[1]) valid_q[1] <= valid_q[0];
      if (load[2]) valid_q[2] <= valid_q[1];
      if (load[3]) valid_q[3] <= valid_q[2];
      if (load[4]) valid_q[4] <= valid_q[3];
    end
  end

  assign al = side0_q.a[ppc_pkg::SPLIT-1:0];
  assign ah = side0_q.a[ppc_pkg::WIDE_W-1:ppc_pkg::SPLIT];
  assign bl = side0_q.b[ppc_pkg::SPLIT-1:0];
  assign bh = side0_q.b[ppc_pkg::WIDE_W-1:ppc_pkg::SPLIT];

  assign accx = (ppc_pkg::ACC_W'(hx_q) <<< ppc_pkg::SPLIT) + ppc_pkg::ACC_W'(lx_q)
              + ppc_pkg::ROUND_HALF;
  assign accy = (ppc_pkg::ACC_W'(hy_q) <<< ppc_pkg::SPLIT) + ppc_pkg::ACC_W'(ly_q)
              + ppc_pkg::ROUND_HALF;

  assign sumx = ppc_pkg::SUM_W'(rx_q) + ppc_pkg::SUM_W'(side3_q.off_x);
  assign sumy = ppc_pkg::SUM_W'(ry_q) + ppc_pkg::SUM_W'(side3_q.off_y);

  always_comb begin
    satx = 1'b0;
    saty = 1'b0;
    x_d  = ppc_pkg::COORD_WIDTH'(sumx);
    y_d  = ppc_pkg::COORD_WIDTH'(sumy);
    if (sumx > ppc_pkg::SUM_W'(ppc_pkg::COORD_MAX)) begin
      x_d  = ppc_pkg::COORD_MAX;
      satx = 1'b1;
    end else if (sumx < ppc_pkg::SUM_W'(ppc_pkg::COORD_MIN)) begin
      x_d  = ppc_pkg::COORD_MIN;
      satx = 1'b1;
    end
    if (sumy > ppc_pkg::SUM_W'(ppc_pkg::COORD_MAX)) begin
      y_d  = ppc_pkg::COORD_MAX;
      saty = 1'b1;
    end else if (sumy < ppc_pkg::SUM_W'(ppc_pkg::COORD_MIN)) begin
      y_d  = ppc_pkg::COORD_MIN;
      saty = 1'b1;
    end
    if (side3_q.zero) begin
      x_d  = '0;
      y_d  = '0;
      satx = 1'b0;
      saty = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[0] && in_valid_i) begin
      c_q     <= in_side_i.flip ? -in_rot_i.x : in_rot_i.x;
      s_q     <= (in_side_i.flip ^ in_side_i.neg) ? -in_rot_i.y : in_rot_i.y;
      side0_q <= in_side_i;
    end
    if (load[1] && valid_q[0]) begin
      alc_q   <= $signed({1'b0, al}) * c_q;
      bls_q   <= $signed({1'b0, bl}) * s_q;
      als_q   <= $signed({1'b0, al}) * s_q;
      blc_q   <= $signed({1'b0, bl}) * c_q;
      ahc_q   <= ah * c_q;
      bhs_q   <= bh * s_q;
      ahs_q   <= ah * s_q;
      bhc_q   <= bh * c_q;
      side1_q <= side0_q;
    end
    if (load[2] && valid_q[1]) begin
      hx_q    <= ppc_pkg::HS_W'(ahc_q) - ppc_pkg::HS_W'(bhs_q);
      lx_q    <= ppc_pkg::LS_W'(alc_q) - ppc_pkg::LS_W'(bls_q);
      hy_q    <= ppc_pkg::HS_W'(ahs_q) + ppc_pkg::HS_W'(bhc_q);
      ly_q    <= ppc_pkg::LS_W'(als_q) + ppc_pkg::LS_W'(blc_q);
      side2_q <= side1_q;
    end
    if (load[3] && valid_q[2]) begin
      rx_q    <= side2_q.skip ? ppc_pkg::ROT_W'(side2_q.a)
                              : accx[ppc_pkg::ACC_W-1:ppc_pkg::TRIG_FRAC];
      ry_q    <= side2_q.skip ? ppc_pkg::ROT_W'(side2_q.b)
                              : accy[ppc_pkg::ACC_W-1:ppc_pkg::TRIG_FRAC];
      side3_q <= side2_q;
    end
    if (load[4] && valid_q[3]) begin
      x_q     <= x_d;
      y_q     <= y_d;
      angle_q <= side3_q.angle;
      sat_q   <= satx | saty;
    end
  end

  assign out_valid_o = valid_q[4];
  assign out_x_o     = x_q;
  assign out_y_o     = y_q;
  assign out_angle_o = angle_q;
  assign saturated_o = sat_q;

endmodule

// ----- rtl/planar_pose_compose.sv -----
// ----------------------------------------------------------------------------
// planar_pose_compose: fixed-point SE(2) pose composition
// Compose into world, map to frame, difference; one pose a cycle if unstalled.
// ----------------------------------------------------------------------------
// A fully pipelined planar pose unit. It takes one request per clock and
// returns one result per clock while the output is not stalled. A request
// passes one input stage, 16 CORDIC cells (one per micro-rotation) and
// five rotate stages (sign fix, split multiply, partial sums, round, offset
// add and clamp). Each stage has its own valid bit, so empty stages close
// up behind a stalled output and the input keeps taking requests until the
// whole pipe is full. Coordinates are signed Q16.16; headings are 16-bit
// binary angles (32768 = pi) and wrap for free. The rotation is computed
// exactly and rounded half up; a zero frame heading skips it. out_x/out_y
// clamp to the 32-bit range and raise saturated. func 3 returns all zeros.
// ----------------------------------------------------------------------------
module planar_pose_compose (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             func_i,
  input  logic signed [ppc_pkg::COORD_WIDTH-1:0] pose_x_i,
  input  logic signed [ppc_pkg::COORD_WIDTH-1:0] pose_y_i,
  input  logic signed [ppc_pkg::ANGLE_WIDTH-1:0] pose_angle_i,
  input  logic signed [ppc_pkg::COORD_WIDTH-1:0] frame_x_i,
  input  logic signed [ppc_pkg::COORD_WIDTH-1:0] frame_y_i,
  input  logic signed [ppc_pkg::ANGLE_WIDTH-1:0] frame_angle_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [ppc_pkg::COORD_WIDTH-1:0] out_x_o,
  output logic signed [ppc_pkg::COORD_WIDTH-1:0] out_y_o,
  output logic signed [ppc_pkg::ANGLE_WIDTH-1:0] out_angle_o,
  output logic                                   saturated_o
);

  localparam int N = ppc_pkg::CORDIC_STAGES;

  // input stage
  logic               prep_valid_q;
  logic               prep_load;
  ppc_pkg::ppc_side_t side_d, side_q;
  ppc_pkg::ppc_rot_t  rot_d, rot_q;

  logic signed [ppc_pkg::WIDE_W-1:0] px_w, py_w, dx, dy;
  logic signed [ppc_pkg::Z_W-1:0]    z_base;
  logic                              fa_zero;

  // cell chain, index 0 is the input stage output
  logic               chain_valid [N+1];
  logic               chain_stall [N+1];
  ppc_pkg::ppc_rot_t  chain_rot   [N+1];
  ppc_pkg::ppc_side_t chain_side  [N+1];

  assign px_w    = ppc_pkg::WIDE_W'(pose_x_i);
  assign py_w    = ppc_pkg::WIDE_W'(pose_y_i);
  assign dx      = px_w - ppc_pkg::WIDE_W'(frame_x_i);
  assign dy      = py_w - ppc_pkg::WIDE_W'(frame_y_i);
  assign fa_zero = (frame_angle_i == '0);
  assign z_base  = ppc_pkg::Z_W'(frame_angle_i) <<< ppc_pkg::ANGLE_SHIFT;

  always_comb begin
    side_d.zero  = 1'b0;
    side_d.skip  = fa_zero;
    side_d.neg   = 1'b0;
    side_d.a     = dx;
    side_d.b     = dy;
    side_d.off_x = '0;
    side_d.off_y = '0;
    side_d.angle = pose_angle_i - frame_angle_i;
    case (ppc_pkg::ppc_func_e'(func_i))
      ppc_pkg::FUNC_COMPOSE: begin
        side_d.a     = px_w;
        side_d.b     = py_w;
        side_d.off_x = frame_x_i;
        side_d.off_y = frame_y_i;
        side_d.angle = pose_angle_i + frame_angle_i;
      end
      ppc_pkg::FUNC_MAP: begin
        side_d.neg   = 1'b1;
      end
      ppc_pkg::FUNC_DIFF: begin
        // same as map without the rotation
        side_d.skip  = 1'b1;
      end
      default: begin
        side_d.zero  = 1'b1;
        side_d.skip  = 1'b1;
        side_d.angle = '0;
      end
    endcase

    // fold the heading into [-pi/2, pi/2]; the result is negated later
    side_d.flip = 1'b0;
    rot_d.x     = ppc_pkg::CORDIC_GAIN;
    rot_d.y     = '0;
    rot_d.z     = z_base;
    if (frame_angle_i > ppc_pkg::QUARTER_TURN) begin
      side_d.flip = 1'b1;
      rot_d.z     = z_base - ppc_pkg::HALF_TURN;
    end else if (frame_angle_i < -ppc_pkg::QUARTER_TURN) begin
      side_d.flip = 1'b1;
      rot_d.z     = z_base + ppc_pkg::HALF_TURN;
    end
  end

  assign prep_load  = !prep_valid_q || !chain_stall[0];
  assign in_stall_o = !prep_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else if (prep_load) begin
      prep_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prep_load && in_valid_i) begin
      side_q <= side_d;
      rot_q  <= rot_d;
    end
  end

  assign chain_valid[0] = prep_valid_q;
  assign chain_rot[0]   = rot_q;
  assign chain_side[0]  = side_q;

  // CORDIC cells, one micro-rotation each
  for (genvar k = 0; k < N; k++) begin : g_cell
    ppc_cordic_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .stage_i     (ppc_pkg::STAGE_W'(k)),
      .in_valid_i  (chain_valid[k]),
      .in_stall_o  (chain_stall[k]),
      .in_rot_i    (chain_rot[k]),
      .in_side_i   (chain_side[k]),
      .out_valid_o (chain_valid[k+1]),
      .out_stall_i (chain_stall[k+1]),
      .out_rot_o   (chain_rot[k+1]),
      .out_side_o  (chain_side[k+1])
    );
  end

  ppc_rotate u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chain_valid[N]),
    .in_stall_o  (chain_stall[N]),
    .in_rot_i    (chain_rot[N]),
    .in_side_i   (chain_side[N]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_angle_o (out_angle_o),
    .saturated_o (saturated_o)
  );

`ifndef SYNTH
  // back-pressure only ever starts at a stalled, valid output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // an accepted request always lands in the input stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> prep_valid_q)
    else $error("accepted request lost at input stage");

  // the saturation flag comes with a clamped coordinate
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (out_x_o == ppc_pkg::COORD_MAX || out_x_o == ppc_pkg::COORD_MIN ||
       out_y_o == ppc_pkg::COORD_MAX || out_y_o == ppc_pkg::COORD_MIN))
    else $error("saturated without a clamped coordinate");
`endif

endmodule

// ----- tb/sv/planar_pose_compose_test.sv -----
// ----------------------------------------------------------------------------
// planar_pose_compose_test: self-checking bench for the planar pose composer
// Drives compose, map-into-frame, plain-difference and unused-mode requests.
// Each accepted request is predicted by an in-bench fixed-point pose model,
// and every accepted result is compared field by field with the oldest
// prediction. Both handshakes idle at random, and a long output hold-off
// fills the pipeline so that the input stall is exercised.
// ----------------------------------------------------------------------------
module planar_pose_compose_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = ppc_pkg::COORD_WIDTH;
  localparam int AW = ppc_pkg::ANGLE_WIDTH;

  localparam logic signed [CW-1:0] COORD_MAX = ppc_pkg::COORD_MAX;
  localparam logic signed [CW-1:0] COORD_MIN = ppc_pkg::COORD_MIN;

  localparam logic [1:0] FUNC_COMPOSE = ppc_pkg::FUNC_COMPOSE;
  localparam logic [1:0] FUNC_MAP     = ppc_pkg::FUNC_MAP;
  localparam logic [1:0] FUNC_DIFF    = ppc_pkg::FUNC_DIFF;
  // Mode value the package enum leaves out: block returns all zeros
  localparam logic [1:0] FUNC_NONE = 2'd3;

  localparam int RANDOM_REQS  = 1330;
  localparam int DRAIN_CYCLES = 40;      // pipe is 22 deep
  localparam int HOLD_CYCLES  = 150;     // long output hold-off
  localparam int HOLD_EVERY   = 400;     // requests between hold-offs
  localparam int HOLD_COUNT   = 2;
  localparam int CYCLE_LIMIT  = 200000;

  // Q2.30 CORDIC gain compensation, start vector is (gain, 0)
  localparam longint TRIG_GAIN = 64'sd652032874;

  typedef struct packed {
    logic [1:0]             func;
    logic signed [CW-1:0]   px;
    logic signed [CW-1:0]   py;
    logic signed [AW-1:0]   pa;
    logic signed [CW-1:0]   fx;
    logic signed [CW-1:0]   fy;
    logic signed [AW-1:0]   fa;
  } pose_req_t;

  typedef struct packed {
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic signed [AW-1:0]   angle;
    logic                   sat;
  } pose_res_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_BEAT
  } rx_mode_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           func_i        = '0;
  logic signed [CW-1:0] pose_x_i      = '0;
  logic signed [CW-1:0] pose_y_i      = '0;
  logic signed [AW-1:0] pose_angle_i  = '0;
  logic signed [CW-1:0] frame_x_i     = '0;
  logic signed [CW-1:0] frame_y_i     = '0;
  logic signed [AW-1:0] frame_angle_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic signed [CW-1:0] out_x_o;
  logic signed [CW-1:0] out_y_o;
  logic signed [AW-1:0] out_angle_o;
  logic                 saturated_o;

  planar_pose_compose i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .pose_x_i      (pose_x_i),
    .pose_y_i      (pose_y_i),
    .pose_angle_i  (pose_angle_i),
    .frame_x_i     (frame_x_i),
    .frame_y_i     (frame_y_i),
    .frame_angle_i (frame_angle_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_angle_o   (out_angle_o),
    .saturated_o   (saturated_o)
  );

  // atan(2^-i) as a 32-bit binary angle, 2^31 = pi
  longint atan_lut [0:15] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41721, 20860
  };

  pose_req_t pending_reqs [$];     // requests not yet offered
  pose_res_t expected_poses [$];   // predictions awaiting their result

  int     mismatches     = 0;
  int     accepted_total = 0;
  int     results_seen   = 0;
  int     clamped_seen   = 0;
  int     in_stall_cycles = 0;
  int     func_count [4] = '{0, 0, 0, 0};
  int     cycle_count    = 0;
  int     hold_left      = 0;
  int     holds_done     = 0;
  logic   req_taken      = 1'b0;

  // --------------------------------------------------------------------------
  // Clock: 10 ns period
  // --------------------------------------------------------------------------
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Pose model
  // --------------------------------------------------------------------------

  // Cosine and sine of a binary heading in Q2.30. Headings past +-pi/2 are
  // turned by half a turn and the vector negated afterwards.
  function automatic void heading_trig(input logic signed [AW-1:0] ang,
                                       output longint cos_q, output longint sin_q);
    longint z, vx, vy, t;
    logic   turned;
    z = longint'(ang) * (64'sd1 <<< (32 - AW));
    vx = TRIG_GAIN;
    vy = 0;
    turned = 1'b0;
    if (z > (64'sd1 <<< 30)) begin
      z = z - (64'sd1 <<< 31);
      turned = 1'b1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z = z + (64'sd1 <<< 31);
      turned = 1'b1;
    end
    for (int i = 0; i < ppc_pkg::CORDIC_STAGES; i++) begin
      if (z >= 0) begin
        t  = vx - (vy >>> i);
        vy = vy + (vx >>> i);
        vx = t;
        z  = z - atan_lut[i];
      end else begin
        t  = vx + (vy >>> i);
        vy = vy - (vx >>> i);
        vx = t;
        z  = z + atan_lut[i];
      end
    end
    cos_q = turned ? -vx : vx;
    sin_q = turned ? -vy : vy;
  endfunction

  // (a*c - b*s) / 2^30, exact product, rounded half up
  function automatic longint rotate_round(input longint a, input longint b,
                                          input longint c, input longint s);
    logic signed [127:0] wa, wb, wc, ws, acc;
    wa = a;
    wb = b;
    wc = c;
    ws = s;
    acc = wa * wc - wb * ws + (128'sd1 <<< 29);
    return longint'(acc >>> 30);
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(input longint v,
                                                       inout logic hit);
    if (v > longint'(COORD_MAX)) begin
      hit = 1'b1;
      return COORD_MAX;
    end
    if (v < longint'(COORD_MIN)) begin
      hit = 1'b1;
      return COORD_MIN;
    end
    return CW'(v);
  endfunction

  function automatic pose_res_t predict_pose(input pose_req_t r);
    pose_res_t res;
    longint    px, py, fx, fy, rx, ry, dx, dy, c, s;
    logic      hit;
    px = r.px;
    py = r.py;
    fx = r.fx;
    fy = r.fy;
    hit = 1'b0;
    res = '0;
    case (r.func)
      FUNC_COMPOSE: begin
        rx = px;
        ry = py;
        if (r.fa != 0) begin
          heading_trig(r.fa, c, s);
          rx = rotate_round(px, py, c, s);
          ry = rotate_round(px, py, s, -c);
        end
        res.x = clamp_coord(rx + fx, hit);
        res.y = clamp_coord(ry + fy, hit);
        res.angle = r.pa + r.fa;
      end
      FUNC_MAP: begin
        dx = px - fx;
        dy = py - fy;
        rx = dx;
        ry = dy;
        if (r.fa != 0) begin
          heading_trig(r.fa, c, s);
          rx = rotate_round(dx, dy, c, -s);
          ry = rotate_round(dy, dx, c, s);
        end
        res.x = clamp_coord(rx, hit);
        res.y = clamp_coord(ry, hit);
        res.angle = r.pa - r.fa;
      end
      FUNC_DIFF: begin
        res.x = clamp_coord(px - fx, hit);
        res.y = clamp_coord(py - fy, hit);
        res.angle = r.pa - r.fa;
      end
      default: hit = 1'b0;   // unused mode: all zeros
    endcase
    res.sat = hit;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_req(input logic [1:0] f,
                         input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
                         input logic signed [AW-1:0] pa,
                         input logic signed [CW-1:0] fx, input logic signed [CW-1:0] fy,
                         input logic signed [AW-1:0] fa);
    pose_req_t r;
    r.func = f;
    r.px = px;
    r.py = py;
    r.pa = pa;
    r.fx = fx;
    r.fy = fy;
    r.fa = fa;
    pending_reqs.push_back(r);
  endtask

  // Modest positions and full-range values in equal share, with zero, +-1 and the extremes mixed in
  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(0, 11))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      3:       return $urandom_range(0, 1) ? CW'(1) : -CW'(1);
      4, 5, 6, 7: return CW'(int'($urandom_range(0, 2097151)) - 1048576);
      default: return CW'($urandom());
    endcase
  endfunction

  // Random heading, sometimes one of the CORDIC corner headings
  function automatic logic signed [AW-1:0] pick_angle();
    if ($urandom_range(0, 5) != 0)
      return AW'($urandom());
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return AW'(1);
      2:       return -AW'(1);
      3:       return AW'(16384);        // exactly +pi/2, no turn
      4:       return -AW'(16384);       // exactly -pi/2, no turn
      5:       return AW'(16385);        // just past pi/2, turned
      6:       return {1'b1, {(AW-1){1'b0}}};  // -pi
      default: return {1'b0, {(AW-1){1'b1}}};  // just under +pi
    endcase
  endfunction

  function automatic logic [1:0] pick_func();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return FUNC_COMPOSE;
    if (roll < 70) return FUNC_MAP;
    if (roll < 95) return FUNC_DIFF;
    return FUNC_NONE;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length separated by random gaps.
  // A request stays on the pins until it is taken. During an output
  // hold-off the gaps are suppressed so the pipe fills and stalls the input.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    pose_req_t nxt;
    logic      nv;
    if (rst_ni && (!in_valid_i || req_taken)) begin
      nv = 1'b0;
      if (gap_left > 0 && hold_left == 0) begin
        gap_left--;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        nv = 1'b1;
        func_i        <= nxt.func;
        pose_x_i      <= nxt.px;
        pose_y_i      <= nxt.py;
        pose_angle_i  <= nxt.pa;
        frame_x_i     <= nxt.fx;
        frame_y_i     <= nxt.fy;
        frame_angle_i <= nxt.fa;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 3))
            0:       gap_left = 0;                       // back-to-back bursts
            1:       gap_left = $urandom_range(5, 15);
            default: gap_left = $urandom_range(1, 3);
          endcase
        end
      end
      in_valid_i <= nv;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: a random pattern that changes after each random-length phase,
  // forced high while a long hold-off is running.
  // --------------------------------------------------------------------------
  rx_mode_e rx_mode       = RX_OPEN;
  int       rx_phase_left = 0;

  always @(negedge clk_i) begin
    logic st;
    if (rx_phase_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_phase_left = $urandom_range(50, 300);
    end else begin
      rx_phase_left--;
    end
    case (rx_mode)
      RX_OPEN:  st = 1'b0;
      RX_LIGHT: st = ($urandom_range(0, 3) == 0);
      RX_HEAVY: st = ($urandom_range(0, 3) != 0);
      default:  st = ((cycle_count % 7) < 3);
    endcase
    if (hold_left > 0)
      st = 1'b1;
    out_stall_i <= st;
  end

  // Long hold-off, counted here in cycles, started after each further HOLD_EVERY
  // accepted requests, at most HOLD_COUNT times
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < HOLD_COUNT &&
                 accepted_total >= HOLD_EVERY * (holds_done + 1)) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Request side: predict each accepted request
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pose_req_t seen;
    req_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && in_stall_o)
      in_stall_cycles <= in_stall_cycles + 1;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      seen.func = func_i;
      seen.px = pose_x_i;
      seen.py = pose_y_i;
      seen.pa = pose_angle_i;
      seen.fx = frame_x_i;
      seen.fy = frame_y_i;
      seen.fa = frame_angle_i;
      expected_poses.push_back(predict_pose(seen));
      func_count[func_i] <= func_count[func_i] + 1;
      accepted_total <= accepted_total + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: compare with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pose_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_poses.size() == 0) begin
        flag_error($sformatf("result %0d with no request outstanding", results_seen));
      end else begin
        want = expected_poses.pop_front();
        if (out_x_o !== want.x)
          flag_error($sformatf("result %0d out_x %0d, expected %0d",
                               results_seen, out_x_o, want.x));
        if (out_y_o !== want.y)
          flag_error($sformatf("result %0d out_y %0d, expected %0d",
                               results_seen, out_y_o, want.y));
        if (out_angle_o !== want.angle)
          flag_error($sformatf("result %0d out_angle %0d, expected %0d",
                               results_seen, out_angle_o, want.angle));
        if (saturated_o !== want.sat)
          flag_error($sformatf("result %0d saturated %b, expected %b",
                               results_seen, saturated_o, want.sat));
      end
      if (saturated_o === 1'b1)
        clamped_seen <= clamped_seen + 1;
      results_seen <= results_seen + 1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, expected_poses.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: load requests, reset, wait for the pipe to drain, report
  // --------------------------------------------------------------------------
  initial begin
    // Directed: zero heading skip, quarter-turn boundaries, turned headings
    add_req(FUNC_COMPOSE, 32'sh0003_0000, 32'sh0001_8000, 16'sd1000, 32'sh0000_4000,
            -32'sh0002_0000, 16'sd0);
    add_req(FUNC_COMPOSE, 32'sh0003_0000, 32'sh0001_8000, 16'sd0, 32'sd0, 32'sd0,
            16'sd16384);
    add_req(FUNC_COMPOSE, 32'sh0003_0000, -32'sh0001_8000, 16'sd0, 32'sd7, -32'sd7,
            -16'sd16384);
    add_req(FUNC_COMPOSE, 32'sh0003_0000, 32'sh0001_8000, -16'sd5, 32'sd0, 32'sd0,
            16'sd16385);
    add_req(FUNC_COMPOSE, -32'sh0005_0000, 32'sh0002_0000, 16'sd0, 32'sd0, 32'sd0,
            {1'b1, {(AW-1){1'b0}}});
    add_req(FUNC_COMPOSE, 32'sh0100_0000, 32'sh0100_0000, 16'sd0, 32'sd0, 32'sd0,
            16'sd32767);
    add_req(FUNC_COMPOSE, COORD_MAX, COORD_MIN, 16'sd0, 32'sd0, 32'sd0, 16'sd1);
    add_req(FUNC_COMPOSE, COORD_MIN, COORD_MAX, 16'sd0, 32'sd0, 32'sd0, -16'sd1);
    // Clamping high and low with the rotation skipped
    add_req(FUNC_COMPOSE, COORD_MAX, COORD_MAX, 16'sd32767, COORD_MAX, COORD_MAX, 16'sd0);
    add_req(FUNC_COMPOSE, COORD_MIN, COORD_MIN, {1'b1, {(AW-1){1'b0}}}, COORD_MIN,
            COORD_MIN, 16'sd0);
    // Heading wrap on compose
    add_req(FUNC_COMPOSE, -32'sd1, 32'sd0, 16'sd32767, 32'sd1, 32'sd0, 16'sd1);
    // Map into frame: skip with overflowing difference, 45 degrees on extremes
    add_req(FUNC_MAP, COORD_MAX, COORD_MIN, 16'sd0, COORD_MIN, COORD_MAX, 16'sd0);
    add_req(FUNC_MAP, COORD_MAX, COORD_MAX, 16'sd100, COORD_MIN, COORD_MIN, 16'sd8192);
    add_req(FUNC_MAP, COORD_MIN, 32'sd0, 16'sd0, COORD_MAX, 32'sd0, -16'sd8192);
    add_req(FUNC_MAP, 32'sh0004_0000, 32'sh0002_0000, 16'sd0, 32'sh0001_0000,
            32'sh0001_0000, {1'b1, {(AW-1){1'b0}}});
    add_req(FUNC_MAP, 32'sh0004_0000, -32'sh0002_0000, -16'sd32768, 32'sh0001_0000,
            32'sd0, 16'sd1);
    // Plain difference: clamp both ways and heading wrap
    add_req(FUNC_DIFF, COORD_MIN, COORD_MAX, 16'sd32767, COORD_MAX, COORD_MIN,
            {1'b1, {(AW-1){1'b0}}});
    add_req(FUNC_DIFF, COORD_MAX, COORD_MIN, {1'b1, {(AW-1){1'b0}}}, COORD_MIN,
            COORD_MAX, 16'sd1);
    add_req(FUNC_DIFF, 32'sd0, 32'sd0, 16'sd0, 32'sd0, 32'sd0, 16'sd0);
    // Unused mode with busy fields must still come back as zeros
    add_req(FUNC_NONE, COORD_MAX, COORD_MIN, 16'sd1234, COORD_MIN, COORD_MAX, 16'sd16384);
    add_req(FUNC_NONE, -32'sd1, -32'sd1, -16'sd1, -32'sd1, -32'sd1, -16'sd1);

    for (int n = 0; n < RANDOM_REQS; n++)
      add_req(pick_func(), pick_coord(), pick_coord(), pick_angle(), pick_coord(),
              pick_coord(), pick_angle());

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // All requests taken, then all results back, then a quiet drain window
    do @(posedge clk_i); while (pending_reqs.size() != 0 || in_valid_i);
    do @(negedge clk_i); while (expected_poses.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests: %0d compose, %0d map, %0d difference, %0d unused mode",
             accepted_total, func_count[FUNC_COMPOSE], func_count[FUNC_MAP],
             func_count[FUNC_DIFF], func_count[FUNC_NONE]);
    $display("%0d results clamped, input held back on %0d cycles, %0d long hold-offs",
             clamped_seen, in_stall_cycles, holds_done);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
